/* hdl/filled_circle_span_generator_assert.svh */
// assertion macros for the filled circle span generator
// used by the top level only, no other dependencies
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_ASSERT_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_ASSERT_SVH

// condition must hold whenever out of reset
`define FCSG_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FCSG_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hdl/fcsg_pkg.sv */
// shared types, constants and functions of the filled circle span generator
// no dependencies
`timescale 1ns / 1ps

package fcsg_pkg;

  localparam int RADIUS_W       = 4;
  localparam int COORD_W        = 10;
  localparam int COLOR_W        = 16;
  localparam int SPAN_X_W       = 11;
  localparam int SPAN_Y_W       = 12;
  localparam int SPAN_LEN_W     = 5;
  localparam int SQ_W           = 8;
  localparam int MAX_RADIUS_DEF = 15;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CENTER,
    S_CHECK,
    S_OUT_UP,
    S_OUT_DN,
    S_IN_UP,
    S_IN_DN,
    S_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    SEL_CENTER,
    SEL_OUT_UP,
    SEL_OUT_DN,
    SEL_IN_UP,
    SEL_IN_DN
  } span_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    span_sel_t sel;
    logic      push;
    logic      dec_h;
    logic      inc_i;
    logic      flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic r_zero;
    logic shrink;
    logic outer;
    logic i_last;
    logic cand_zero;
    logic pend_valid;
    logic out_free;
  } sts_t;

  // floor(r * 0.707) + 1, the last row offset of the walk
  function automatic logic [RADIUS_W-1:0] imax_of(input logic [RADIUS_W-1:0] r);
    logic [RADIUS_W-1:0] v;
    begin
      case (r)
        4'd0:    v = 4'd0;
        4'd1:    v = 4'd0;
        4'd2:    v = 4'd1;
        4'd3:    v = 4'd2;
        4'd4:    v = 4'd2;
        4'd5:    v = 4'd3;
        4'd6:    v = 4'd4;
        4'd7:    v = 4'd4;
        4'd8:    v = 4'd5;
        4'd9:    v = 4'd6;
        4'd10:   v = 4'd7;
        4'd11:   v = 4'd7;
        4'd12:   v = 4'd8;
        4'd13:   v = 4'd9;
        4'd14:   v = 4'd9;
        4'd15:   v = 4'd10;
        default: v = 4'd0;
      endcase
      return v + 4'd1;
    end
  endfunction

endpackage

/* hdl/fcsg_ctrl.sv */
// controller state machine of the filled circle span generator
// depends on fcsg_pkg
`timescale 1ns / 1ps

module fcsg_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  fcsg_pkg::sts_t sts,
  output fcsg_pkg::cmd_t cmd,
  output logic         busy
);
  import fcsg_pkg::*;

  state_t state;
  state_t state_next;
  logic   can_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // a span may go forward when it is dropped, or the pending slot can be refilled
  assign can_go = sts.cand_zero || !sts.pend_valid || sts.out_free;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = SEL_CENTER;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!sts.r_zero) state_next = S_CENTER;
        end
      end
      S_CENTER: begin
        cmd.sel = SEL_CENTER;
        if (can_go) begin
          cmd.push   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.shrink && sts.outer) begin
          state_next = S_OUT_UP;
        end else begin
          cmd.dec_h  = sts.shrink;
          state_next = S_IN_UP;
        end
      end
      S_OUT_UP: begin
        cmd.sel = SEL_OUT_UP;
        if (can_go) begin
          cmd.push   = 1'b1;
          state_next = S_OUT_DN;
        end
      end
      S_OUT_DN: begin
        cmd.sel = SEL_OUT_DN;
        if (can_go) begin
          cmd.push   = 1'b1;
          cmd.dec_h  = 1'b1;
          state_next = S_IN_UP;
        end
      end
      S_IN_UP: begin
        cmd.sel = SEL_IN_UP;
        if (can_go) begin
          cmd.push   = 1'b1;
          state_next = S_IN_DN;
        end
      end
      S_IN_DN: begin
        cmd.sel = SEL_IN_DN;
        if (can_go) begin
          cmd.push = 1'b1;
          if (sts.i_last) begin
            state_next = S_FLUSH;
          end else begin
            cmd.inc_i  = 1'b1;
            state_next = S_CHECK;
          end
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/fcsg_dp.sv */
// datapath of the filled circle span generator: radius register, walk
// counters, span arithmetic, pending span and output register; uses fcsg_pkg
`timescale 1ns / 1ps

module fcsg_dp #(
  parameter int MAX_RADIUS = fcsg_pkg::MAX_RADIUS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                radius_we,
  input  logic [fcsg_pkg::RADIUS_W-1:0]       radius_wdata,
  input  logic [fcsg_pkg::COORD_W-1:0]        center_x,
  input  logic [fcsg_pkg::COORD_W-1:0]        center_y,
  input  logic [fcsg_pkg::COLOR_W-1:0]        pixel_color,
  input  fcsg_pkg::cmd_t                      cmd,
  output fcsg_pkg::sts_t                      sts,
  output logic                                span_valid,
  input  logic                                span_stall,
  output logic signed [fcsg_pkg::SPAN_X_W-1:0] span_x,
  output logic signed [fcsg_pkg::SPAN_Y_W-1:0] span_y,
  output logic [fcsg_pkg::SPAN_LEN_W-1:0]     span_length,
  output logic [fcsg_pkg::COLOR_W-1:0]        span_color,
  output logic                                last_span
);
  import fcsg_pkg::*;

  logic [RADIUS_W-1:0] radius;
  logic [RADIUS_W-1:0] r_eff;

  logic [COORD_W-1:0]  cx;
  logic [COORD_W-1:0]  cy;
  logic [COLOR_W-1:0]  color;
  logic [RADIUS_W-1:0] imax;
  logic [SQ_W-1:0]     sqmax;
  logic [RADIUS_W-1:0] i;
  logic [RADIUS_W-1:0] h;

  logic [SQ_W:0]       dist_sq;
  logic [RADIUS_W-1:0] x_amt;
  logic [RADIUS_W-1:0] y_amt;
  logic                y_down;
  logic [RADIUS_W-1:0] len_amt;
  logic                x_plus1;
  logic [SPAN_X_W-1:0]   cand_x;
  logic [SPAN_Y_W-1:0]   cand_y;
  logic [SPAN_LEN_W-1:0] cand_len;

  logic                  pend_valid;
  logic [SPAN_X_W-1:0]   pend_x;
  logic [SPAN_Y_W-1:0]   pend_y;
  logic [SPAN_LEN_W-1:0] pend_len;

  // radius register; the value used (r_eff) is clamped to the configured maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (radius_we) begin
      radius <= radius_wdata;
    end
  end

  assign r_eff = ({2'b00, radius} > 6'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius;

  // circle parameters and walk counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx    <= center_x;
      cy    <= center_y;
      color <= pixel_color;
      imax  <= imax_of(r_eff);
      sqmax <= SQ_W'({4'b0, r_eff} * {4'b0, r_eff}) + SQ_W'(r_eff[RADIUS_W-1:1]);
      i     <= 4'd1;
      h     <= r_eff;
    end else begin
      if (cmd.inc_i) i <= i + 4'd1;
      if (cmd.dec_h && (h != '0)) h <= h - 4'd1;
    end
  end

  assign dist_sq = (SQ_W+1)'(SQ_W'({4'b0, i} * {4'b0, i}))
                 + (SQ_W+1)'(SQ_W'({4'b0, h} * {4'b0, h}));

  assign sts.r_zero = (r_eff == '0);
  assign sts.shrink = (dist_sq > {1'b0, sqmax});
  assign sts.outer  = (h > imax);
  assign sts.i_last = (i == imax);

  // candidate span for the selected position
  always_comb begin
    x_amt   = h;
    x_plus1 = 1'b0;
    y_amt   = i;
    y_down  = 1'b0;
    len_amt = h;
    case (cmd.sel)
      SEL_CENTER: begin
        x_amt   = h;
        y_amt   = '0;
        len_amt = h;
      end
      SEL_OUT_UP: begin
        x_amt   = i;
        x_plus1 = 1'b1;
        y_amt   = h;
        len_amt = i - 4'd1;
      end
      SEL_OUT_DN: begin
        x_amt   = i;
        x_plus1 = 1'b1;
        y_amt   = h;
        y_down  = 1'b1;
        len_amt = i - 4'd1;
      end
      SEL_IN_UP: begin
        y_amt = i;
      end
      SEL_IN_DN: begin
        y_amt  = i;
        y_down = 1'b1;
      end
      default: begin
        len_amt = '0;
      end
    endcase
  end

  assign cand_x   = {1'b0, cx} - {7'b0, x_amt} + {10'b0, x_plus1};
  assign cand_y   = y_down ? ({2'b00, cy} - {8'b0, y_amt}) : ({2'b00, cy} + {8'b0, y_amt});
  assign cand_len = {len_amt, 1'b0};

  assign sts.cand_zero  = (len_amt == '0);
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = !span_valid || !span_stall;

  // one-deep pending span so the final one can be flagged
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.push && !sts.cand_zero) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !sts.cand_zero) begin
      pend_x   <= cand_x;
      pend_y   <= cand_y;
      pend_len <= cand_len;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if ((cmd.push && !sts.cand_zero && pend_valid) || (cmd.flush && pend_valid)) begin
      span_valid <= 1'b1;
    end else if (!span_stall) begin
      span_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.push && !sts.cand_zero && pend_valid) || (cmd.flush && pend_valid)) begin
      span_x      <= pend_x;
      span_y      <= pend_y;
      span_length <= pend_len;
      span_color  <= color;
      last_span   <= cmd.flush;
    end
  end

endmodule

/* hdl/filled_circle_span_generator.sv */
// top level of the filled circle span generator: controller plus datapath
// depends on fcsg_pkg, fcsg_ctrl, fcsg_dp and the assertion macro header
`timescale 1ns / 1ps
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  config    | radius_we              | radius_wdata
//  input     | in_valid / in_stall    | center_x, center_y, pixel_color
//  output    | span_valid / span_stall| span_x, span_y, span_length, span_color,
//            |                        | last_span
//
//  one transaction in gives one circle: a load step in idle, then a center row
//  step, then a row walk of imax = floor(0.707 r) + 1 offsets, each a compare
//  step plus one step per candidate span (outer pair if needed, inner pair),
//  then a flush step; the controller steps one span per cycle while span_stall
//  does not hold the walk
//  in_stall is high for the whole walk; a radius of zero gives no spans
//  span_stall holds the walk only when the pending span and the output
//  register are both full; synchronous active-high reset, radius resets to 2

module filled_circle_span_generator #(
  parameter int MAX_RADIUS = fcsg_pkg::MAX_RADIUS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // radius register write
  input  logic                                 radius_we,
  input  logic [fcsg_pkg::RADIUS_W-1:0]        radius_wdata,
  // circle transactions
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [fcsg_pkg::COORD_W-1:0]         center_x,
  input  logic [fcsg_pkg::COORD_W-1:0]         center_y,
  input  logic [fcsg_pkg::COLOR_W-1:0]         pixel_color,
  // span transactions
  output logic                                 span_valid,
  input  logic                                 span_stall,
  output logic signed [fcsg_pkg::SPAN_X_W-1:0] span_x,
  output logic signed [fcsg_pkg::SPAN_Y_W-1:0] span_y,
  output logic [fcsg_pkg::SPAN_LEN_W-1:0]      span_length,
  output logic [fcsg_pkg::COLOR_W-1:0]         span_color,
  output logic                                 last_span
);
  import fcsg_pkg::*;

  `include "filled_circle_span_generator_assert.svh"

  cmd_t cmd;   // load, span select, push, counter steps, flush
  sts_t sts;   // compare results and buffer occupancy
  logic busy;

  // controller walks center row, then per offset: compare, outer pair if needed, inner pair
  fcsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  // datapath holds the circle, forms spans and delays them by one to flag the last
  fcsg_dp #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .radius_we    (radius_we),
    .radius_wdata (radius_wdata),
    .center_x     (center_x),
    .center_y     (center_y),
    .pixel_color  (pixel_color),
    .cmd          (cmd),
    .sts          (sts),
    .span_valid   (span_valid),
    .span_stall   (span_stall),
    .span_x       (span_x),
    .span_y       (span_y),
    .span_length  (span_length),
    .span_color   (span_color),
    .last_span    (last_span)
  );

  // a new circle is taken only when idle
  assign in_stall = busy;

  // an idle block never has a span left in the pending slot
  `FCSG_ASSERT_IMPLIES(a_idle_no_pending, clk, rst, !busy, !sts.pend_valid, "pending span while idle")
  // a zero-length span never reaches the output
  `FCSG_ASSERT_IMPLIES(a_len_nonzero, clk, rst, span_valid, span_length != '0, "zero-length span")
  // moving the pending span out requires a free output register
  `FCSG_ASSERT_ALWAYS(a_no_overwrite, clk, rst, !(((cmd.push && !sts.cand_zero) || cmd.flush) && sts.pend_valid && !sts.out_free), "output overwritten")
  // a load and a push never coincide
  `FCSG_ASSERT_ALWAYS(a_load_excl, clk, rst, !(cmd.load && (cmd.push || cmd.flush)), "load during walk")

endmodule

/* tb/sv/tb_filled_circle_span_generator.sv */
// testbench for the filled circle span generator: random and directed circle stamps
// checked span by span against a span predictor; depends on fcsg_pkg and the rtl top
`timescale 1ns / 1ps

module tb_filled_circle_span_generator;
  import fcsg_pkg::*;

  // wait long enough for one full walk of the block at r=15 with no stalls
  localparam int WALK_CYCLES = 64;
  // hard stop for the whole run, several times the slowest legal run
  localparam int TIMEOUT_NS = 5_000_000;
  localparam int SPAN_MAX_RADIUS = MAX_RADIUS_DEF;

  // one expected span transaction
  typedef struct {
    logic signed [SPAN_X_W-1:0] x;
    logic signed [SPAN_Y_W-1:0] y;
    logic [SPAN_LEN_W-1:0]      len;
    logic [COLOR_W-1:0]         color;
    logic                       is_last;
  } span_t;

  // span predictor plus the queue of spans still owed by the block
  class span_scoreboard;
    span_t               expected_spans[$];
    span_t               walk[$];
    logic [RADIUS_W-1:0] radius;
    int unsigned         mismatch_count;

    function new();
      radius = RADIUS_RESET;
      mismatch_count = 0;
    endfunction

    function void report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
    endfunction

    // zero-length spans are never emitted
    function void add_span(input int x, input int y, input int len,
                           input logic [COLOR_W-1:0] color);
      span_t s;
      if (len == 0) return;
      s.x = SPAN_X_W'(x);
      s.y = SPAN_Y_W'(y);
      s.len = SPAN_LEN_W'(len);
      s.color = color;
      s.is_last = 1'b0;
      walk.push_back(s);
    endfunction

    // row walk of one circle: center row, then offsets out to floor(0.707 r) + 1
    function void predict_circle(input logic [COORD_W-1:0] cx_in,
                                 input logic [COORD_W-1:0] cy_in,
                                 input logic [COLOR_W-1:0] color);
      int    cx, cy, r, row_last, limit_sq, h, i, k;
      span_t s;
      cx = int'(cx_in);
      cy = int'(cy_in);
      r = int'(radius);
      if (r > SPAN_MAX_RADIUS) r = SPAN_MAX_RADIUS;
      if (r == 0) return;
      walk.delete();
      row_last = (r * 707) / 1000 + 1;
      limit_sq = r * r + r / 2;
      h = r;
      add_span(cx - r, cy, 2 * r, color);
      for (i = 1; i <= row_last; i++) begin
        if (i * i + h * h > limit_sq) begin
          // outer caps while the half width is still beyond the walk limit
          if (h > row_last) begin
            add_span(cx - i + 1, cy + h, 2 * (i - 1), color);
            add_span(cx - i + 1, cy - h, 2 * (i - 1), color);
          end
          if (h > 0) h--;
        end
        add_span(cx - h, cy + i, 2 * h, color);
        add_span(cx - h, cy - i, 2 * h, color);
      end
      for (k = 0; k < walk.size(); k++) begin
        s = walk[k];
        s.is_last = (k == walk.size() - 1);
        expected_spans.push_back(s);
      end
    endfunction

    function void check_span(input logic signed [SPAN_X_W-1:0] x,
                             input logic signed [SPAN_Y_W-1:0] y,
                             input logic [SPAN_LEN_W-1:0]      len,
                             input logic [COLOR_W-1:0]         color,
                             input logic                       is_last);
      span_t w;
      if (expected_spans.size() == 0) begin
        report_mismatch($sformatf("span x=%0d y=%0d len=%0d with nothing expected",
                                  x, y, len));
        return;
      end
      w = expected_spans.pop_front();
      if (x !== w.x)
        report_mismatch($sformatf("span_x got %0d want %0d", x, w.x));
      if (y !== w.y)
        report_mismatch($sformatf("span_y got %0d want %0d", y, w.y));
      if (len !== w.len)
        report_mismatch($sformatf("span_length got %0d want %0d", len, w.len));
      if (color !== w.color)
        report_mismatch($sformatf("span_color got %h want %h", color, w.color));
      if (is_last !== w.is_last)
        report_mismatch($sformatf("last_span got %b want %b", is_last, w.is_last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       radius_we    = 1'b0;
  logic [RADIUS_W-1:0]        radius_wdata = '0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic [COORD_W-1:0]         center_x     = '0;
  logic [COORD_W-1:0]         center_y     = '0;
  logic [COLOR_W-1:0]         pixel_color  = '0;
  logic                       span_valid;
  logic                       span_stall   = 1'b0;
  logic signed [SPAN_X_W-1:0] span_x;
  logic signed [SPAN_Y_W-1:0] span_y;
  logic [SPAN_LEN_W-1:0]      span_length;
  logic [COLOR_W-1:0]         span_color;
  logic                       last_span;

  // idle odds in percent, changed per phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  span_scoreboard sb;

  filled_circle_span_generator dut (
    .clk          (clk),
    .rst          (rst),
    .radius_we    (radius_we),
    .radius_wdata (radius_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .center_x     (center_x),
    .center_y     (center_y),
    .pixel_color  (pixel_color),
    .span_valid   (span_valid),
    .span_stall   (span_stall),
    .span_x       (span_x),
    .span_y       (span_y),
    .span_length  (span_length),
    .span_color   (span_color),
    .last_span    (last_span)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    span_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: everything is sampled at the edge, before any nonblocking update lands
  always @(posedge clk) begin
    if (!rst) begin
      // register write keeps the predictor's copy of the radius in step
      if (radius_we) sb.radius = radius_wdata;
      // input transaction accepted: predict all its spans now
      if (in_valid && !in_stall) sb.predict_circle(center_x, center_y, pixel_color);
      // span transaction accepted: compare against the oldest prediction
      if (span_valid && !span_stall)
        sb.check_span(span_x, span_y, span_length, span_color, last_span);
    end
  end

  // one circle transaction, with random idle cycles in front of it
  task automatic send_circle(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                             input logic [COLOR_W-1:0] color);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    center_x    <= cx;
    center_y    <= cy;
    pixel_color <= color;
    @(posedge clk);
    // payload holds while the block is busy walking the previous circle
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait for every predicted span to come out; the first
  // edge lets the monitor record a transaction accepted at the current edge
  task automatic drain_spans();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_spans.size() != 0) @(posedge clk);
  endtask

  // radius changes only with the block idle; a radius-zero circle leaves
  // nothing in the queue, so also let a full walk time pass
  task automatic change_radius(input logic [RADIUS_W-1:0] v);
    drain_spans();
    repeat (WALK_CYCLES) @(posedge clk);
    radius_we    <= 1'b1;
    radius_wdata <= v;
    @(posedge clk);
    radius_we <= 1'b0;
  endtask

  initial begin
    int unsigned phase, chunk, k, pick;
    logic [RADIUS_W-1:0] rad;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset radius of 2 first: corners of the coordinate range
    // and extreme colors, so spans fall off the left, top, right and bottom edges
    send_circle(10'd0, 10'd0, 16'h0000);
    send_circle(10'd1023, 10'd1023, 16'hffff);
    send_circle(10'd512, 10'd0, 16'h5555);
    send_circle(10'd0, 10'd1023, 16'haaaa);

    // largest radius: outer caps appear and the walk is longest
    change_radius(4'd15);
    send_circle(10'd0, 10'd0, 16'hffff);
    send_circle(10'd1023, 10'd1023, 16'h0000);
    send_circle(10'd1023, 10'd0, 16'h1234);

    // smallest nonzero radius
    change_radius(4'd1);
    send_circle(10'd5, 10'd5, 16'h8001);
    send_circle(10'd0, 10'd0, 16'h7ffe);

    // odd radius, still too small for outer caps
    change_radius(4'd3);
    send_circle(10'd300, 10'd700, 16'hc3c3);

    // radius zero: circles are taken but give no spans at all
    change_radius(4'd0);
    send_circle(10'd100, 10'd100, 16'hdead);
    send_circle(10'd1023, 10'd1023, 16'hbeef);
    change_radius(4'd7);
    send_circle(10'd511, 10'd512, 16'h0f0f);

    // random part: four idle patterns, three radius settings in each
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
      endcase
      for (chunk = 0; chunk < 3; chunk++) begin
        // favor the extremes of the radius range
        pick = $urandom_range(99);
        if (pick < 15) rad = 4'd0;
        else if (pick < 30) rad = 4'd15;
        else if (pick < 40) rad = 4'd1;
        else rad = RADIUS_W'($urandom_range(15, 1));
        change_radius(rad);
        for (k = 0; k < 9; k++) begin
          // sender holds off once until the block has flushed everything
          if (phase == 3 && chunk == 1 && k == 5) drain_spans();
          send_circle(COORD_W'($urandom_range(1023)), COORD_W'($urandom_range(1023)),
                      COLOR_W'($urandom_range(65535)));
        end
      end
    end

    drain_spans();
    recv_stall_pct = 0;
    // anything emitted after this point has no prediction and is flagged
    repeat (WALK_CYCLES) @(posedge clk);
    if (sb.expected_spans.size() != 0)
      sb.report_mismatch($sformatf("%0d spans never arrived", sb.expected_spans.size()));
    if (sb.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #(TIMEOUT_NS);
    sb.report_mismatch($sformatf("timeout, %0d spans still expected",
                                 sb.expected_spans.size()));
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/fcsg_pkg.sv
hdl/fcsg_ctrl.sv
hdl/fcsg_dp.sv
hdl/filled_circle_span_generator.sv
tb/sv/tb_filled_circle_span_generator.sv
